// ===== hdl/cgf_pkg.sv =====
// ----------------------------------------------------------------------------
// cgf_pkg
// Shared types and constants of the coverage gap finder: beat payloads,
// controller states and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package cgf_pkg;

  localparam int POS_W   = 18;             // position width
  localparam int CNT_W   = 19;             // cursor, start and length width
  localparam int BIT_W   = 6;              // bit index inside a map word
  localparam int WORD_W  = POS_W - BIT_W;  // map word index of a position
  localparam int MAP_W   = 64;             // bits per map word
  localparam int POS_TOP = 2 ** POS_W - 1; // largest position a field can carry

  localparam logic [CNT_W-1:0] MIN_GAP_RESET = 19'd300;

  localparam logic OP_MARK = 1'b0;
  localparam logic OP_GAP  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;
    logic             restart;
  } cgf_in_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] gap_start;
    logic [POS_W-1:0] gap_end;
    logic [CNT_W-1:0] gap_length;
  } cgf_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_MARK_TAIL,
    ST_SCAN_START,
    ST_SCAN_EVAL
  } cgf_state_t;

  typedef struct packed {
    logic clr_wr;       // write a zero word at the sweep address
    logic accept;       // take the request beat
    logic mark_rd;      // read the next map word of the mark span
    logic scan_rd_cur;  // read the map word under the scan cursor
    logic scan_rd_next; // read the map word of the advanced cursor
    logic scan_commit;  // apply one scan step
    logic load_found;   // load a gap into the result register
    logic load_done;    // load an end-of-scan result
  } cgf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mark_empty;
    logic mark_last;
    logic past_end;
    logic ev_any;
    logic ev_hit;
    logic ev_done;
    logic ev_same_word;
    logic out_free;
  } cgf_sts_t;

endpackage

// ===== hdl/coverage_gap_finder_top.sv =====
// ----------------------------------------------------------------------------
// coverage_gap_finder_top
// Coverage bitmap with interval marking and a resumable scan for uncovered
// runs of at least min_gap_length positions.
// ----------------------------------------------------------------------------
// After reset the map is swept clear, one 64-position word a cycle, before
// the first request is taken; configuration writes are taken during the
// sweep. Items are handled one at a time through a map memory with one write
// port and one registered read port. A mark is a read-modify-write walk over
// the map words from left/64 to right/64; a reversed interval is accepted
// without a walk. A next-gap request scans the map word by word, since the
// evaluation unit handles one word and stops at each covered position; a
// finished result waits in the result register while the next request is
// taken, and a later scan holds its own result until that register is free.
// ----------------------------------------------------------------------------
module coverage_gap_finder_top #(
  parameter int POSITIONS = 262144
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  cgf_pkg::cgf_in_t          req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output cgf_pkg::cgf_out_t         rsp,
  input  logic                      cfg_we,
  input  logic [cgf_pkg::CNT_W-1:0] cfg_wdata
);
  import cgf_pkg::*;

  cgf_cmd_t cmd;
  cgf_sts_t sts;

  cgf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.op),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cgf_datapath #(
    .POSITIONS (POSITIONS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== hdl/cgf_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgf_ctrl
// Sequencer of the coverage gap finder: clearing sweep after reset, mark
// read-modify-write walk and the word-by-word gap scan.
// ----------------------------------------------------------------------------
module cgf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_op,
  output logic              req_ready,
  input  cgf_pkg::cgf_sts_t sts,
  output cgf_pkg::cgf_cmd_t cmd
);
  import cgf_pkg::*;

  cgf_state_t state;
  cgf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req_op == OP_GAP) begin
            state_next = ST_SCAN_START;
          end else if (!sts.mark_empty) begin
            state_next = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        if (sts.mark_last) state_next = ST_MARK_TAIL;
      end
      ST_MARK_TAIL: begin
        state_next = ST_IDLE;
      end
      ST_SCAN_START: begin
        if (sts.past_end) begin
          if (sts.out_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN_EVAL;
        end
      end
      ST_SCAN_EVAL: begin
        if (sts.ev_any && sts.ev_hit) begin
          if (sts.out_free) state_next = ST_IDLE;
        end else if (sts.ev_done) begin
          state_next = ST_SCAN_START;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ST_MARK: begin
        cmd.mark_rd = 1'b1;
      end
      ST_MARK_TAIL: begin
        cmd = '0;
      end
      ST_SCAN_START: begin
        if (sts.past_end) begin
          cmd.load_done = sts.out_free;
        end else begin
          cmd.scan_rd_cur = 1'b1;
        end
      end
      ST_SCAN_EVAL: begin
        if (sts.ev_any && sts.ev_hit) begin
          cmd.load_found  = sts.out_free;
          cmd.scan_commit = sts.out_free;
        end else begin
          cmd.scan_commit = 1'b1;
          // fetch the next word now; one word a cycle while no bit is covered
          cmd.scan_rd_next = !sts.ev_done && !sts.ev_same_word;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_found || cmd.load_done) |-> sts.out_free)
    else $error("result loaded while the result register is busy");

  a_mark_walk: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_op == OP_MARK && !sts.mark_empty)
      |=> state == ST_MARK)
    else $error("mark beat did not start the map walk");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == ST_IDLE)
    else $error("request taken outside the idle state");
`endif

endmodule

// ===== hdl/cgf_datapath.sv =====
// ----------------------------------------------------------------------------
// cgf_datapath
// Coverage map memory (64-bit words), mark bounds, scan registers, gap
// evaluation over one map word and the result register.
// ----------------------------------------------------------------------------
module cgf_datapath #(
  parameter int POSITIONS = 262144
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cgf_pkg::cgf_in_t           req,
  input  logic                       cfg_we,
  input  logic [cgf_pkg::CNT_W-1:0]  cfg_wdata,
  input  cgf_pkg::cgf_cmd_t          cmd,
  output cgf_pkg::cgf_sts_t          sts,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output cgf_pkg::cgf_out_t          rsp
);
  import cgf_pkg::*;

  localparam int WORDS    = (POSITIONS + MAP_W - 1) / MAP_W;
  localparam int AW       = $clog2(WORDS);
  localparam int LAST_POS = (POSITIONS - 1 > POS_TOP) ? POS_TOP : POSITIONS - 1;
  localparam logic [POS_W-1:0] LAST_POS_V = POS_W'(LAST_POS);
  localparam logic [AW-1:0]    LAST_WORD  = AW'(WORDS - 1);

  function automatic logic [MAP_W-1:0] range_mask(input logic [BIT_W-1:0] lo,
                                                  input logic [BIT_W-1:0] hi);
    logic [MAP_W-1:0] m;
    begin
      m = ({MAP_W{1'b1}} << lo) & ({MAP_W{1'b1}} >> (BIT_W'(MAP_W - 1) - hi));
      return m;
    end
  endfunction

  function automatic logic [BIT_W-1:0] first_set(input logic [MAP_W-1:0] w);
    logic [BIT_W-1:0] idx;
    begin
      idx = '0;
      for (int i = MAP_W - 1; i >= 0; i--) begin
        if (w[i]) idx = BIT_W'(i);
      end
      return idx;
    end
  endfunction

  // map memory
  logic [MAP_W-1:0] map_mem [WORDS];
  logic [MAP_W-1:0] rd_word;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [MAP_W-1:0] mem_wdata;

  // control state
  logic [AW-1:0]    clr_addr;
  logic             wr_pend;
  logic [CNT_W-1:0] min_gap;
  logic [POS_W-1:0] hm;
  logic [CNT_W-1:0] cursor;
  logic [POS_W-1:0] last_cov;
  logic [CNT_W-1:0] run;

  // mark walk
  logic [POS_W-1:0]  mk_lo;
  logic [POS_W-1:0]  mk_hi;
  logic [WORD_W-1:0] mark_word;
  logic [WORD_W-1:0] wr_word;
  logic [POS_W-1:0]  right_clip;
  logic [BIT_W-1:0]  wr_lo;
  logic [BIT_W-1:0]  wr_hi;

  // scan step
  logic [WORD_W-1:0] cur_word;
  logic [BIT_W-1:0]  off;
  logic [BIT_W-1:0]  lim;
  logic [MAP_W-1:0]  masked;
  logic              any;
  logic [BIT_W-1:0]  f;
  logic [POS_W-1:0]  p;
  logic [CNT_W-1:0]  cnt_hit;
  logic [CNT_W-1:0]  cnt_miss;
  logic [CNT_W-1:0]  nc;

  always_comb begin
    right_clip = (req.right > LAST_POS_V) ? LAST_POS_V : req.right;
  end

  always_comb begin
    wr_lo = (wr_word == mk_lo[POS_W-1:BIT_W]) ? mk_lo[BIT_W-1:0] : '0;
    wr_hi = (wr_word == mk_hi[POS_W-1:BIT_W]) ? mk_hi[BIT_W-1:0] : '1;
  end

  always_comb begin
    cur_word = cursor[POS_W-1:BIT_W];
    off      = cursor[BIT_W-1:0];
    lim      = (hm[POS_W-1:BIT_W] == cur_word) ? hm[BIT_W-1:0] : '1;
    masked   = rd_word & range_mask(off, lim);
    any      = |masked;
    f        = first_set(masked);
    p        = {cur_word, f};
    cnt_hit  = run + CNT_W'(f - off);
    cnt_miss = run + CNT_W'({1'b0, lim} - {1'b0, off} + 7'd1);
    nc       = any ? (CNT_W'(p) + 1'b1) : (CNT_W'({cur_word, lim}) + 1'b1);
  end

  always_comb begin
    mem_we    = cmd.clr_wr | wr_pend;
    mem_waddr = cmd.clr_wr ? clr_addr : AW'(wr_word);
    mem_wdata = cmd.clr_wr ? '0 : (rd_word | range_mask(wr_lo, wr_hi));
    mem_re    = cmd.mark_rd | cmd.scan_rd_cur | cmd.scan_rd_next;
    if (cmd.mark_rd) begin
      mem_raddr = AW'(mark_word);
    end else if (cmd.scan_rd_next) begin
      mem_raddr = AW'(nc[POS_W-1:BIT_W]);
    end else begin
      mem_raddr = AW'(cur_word);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_word <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      wr_pend  <= 1'b0;
      min_gap  <= MIN_GAP_RESET;
      hm       <= '0;
      cursor   <= '0;
      last_cov <= '0;
      run      <= '0;
    end else begin
      if (cmd.clr_wr) clr_addr <= clr_addr + 1'b1;
      wr_pend <= cmd.mark_rd;
      if (cfg_we) min_gap <= cfg_wdata;
      if (cmd.accept) begin
        if (req.op == OP_MARK) begin
          if (right_clip > hm) hm <= right_clip;
        end else if (req.restart) begin
          cursor   <= '0;
          last_cov <= '0;
          run      <= '0;
        end
      end
      if (cmd.scan_commit) begin
        cursor <= nc;
        if (any) begin
          last_cov <= p;
          run      <= '0;
        end else begin
          run <= cnt_miss;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && req.op == OP_MARK) begin
      mk_lo     <= req.left;
      mk_hi     <= right_clip;
      mark_word <= req.left[POS_W-1:BIT_W];
    end else if (cmd.mark_rd) begin
      mark_word <= mark_word + 1'b1;
    end
    if (cmd.mark_rd) wr_word <= mark_word;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_found || cmd.load_done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_found) begin
      rsp.found      <= 1'b1;
      rsp.gap_start  <= CNT_W'(last_cov) + 1'b1;
      rsp.gap_end    <= p - 1'b1;
      rsp.gap_length <= cnt_hit;
    end else if (cmd.load_done) begin
      rsp <= '0;
    end
  end

  always_comb begin
    sts.clr_last     = (clr_addr == LAST_WORD);
    sts.mark_empty   = (req.left > right_clip);
    sts.mark_last    = (mark_word == mk_hi[POS_W-1:BIT_W]);
    sts.past_end     = (cursor > CNT_W'(hm));
    sts.ev_any       = any;
    sts.ev_hit       = (cnt_hit >= min_gap);
    sts.ev_done      = (nc > CNT_W'(hm));
    sts.ev_same_word = (nc[CNT_W-1:BIT_W] == cursor[CNT_W-1:BIT_W]);
    sts.out_free     = !rsp_valid || rsp_ready;
  end

`ifndef ASSERT_OFF
  a_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> $past(cmd.mark_rd))
    else $error("map write without the matching read");

  a_no_clear_collision: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_wr |-> !wr_pend)
    else $error("clearing sweep overlaps a mark write");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= CNT_W'(hm) + 1'b1)
    else $error("scan cursor ran past the highest mark");
`endif

endmodule
